// ----- hdl/vfpd_pkg.sv -----
// vfpd_pkg: types and fixed constants shared by the voxel first-point dedup block
// used by vfpd_key, vfpd_table, vfpd_checker and the top level
// no dependencies
package vfpd_pkg;

    // fixed field widths
    localparam int COORD_W     = 32;
    localparam int INV_W       = 24;
    localparam int PROD_W      = 57;
    localparam int OUT_INDEX_W = 20;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 24;

    // reset inverse voxel size, 10.0 per metre in Q8.16
    localparam logic [INV_W-1:0] INV_RESET = 24'd655360;

    // hash primes, x in the lowest word
    localparam logic [31:0] PRIME_X = 32'd73856093;
    localparam logic [31:0] PRIME_Y = 32'd19349663;
    localparam logic [31:0] PRIME_Z = 32'd83492791;
    localparam logic [2:0][31:0] PRIMES = {PRIME_Z, PRIME_Y, PRIME_X};

    // configuration register indexes
    localparam logic [1:0] CFG_INV_X = 2'd0;
    localparam logic [1:0] CFG_INV_Y = 2'd1;
    localparam logic [1:0] CFG_INV_Z = 2'd2;

    // input item kinds
    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // top level control
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_KEY,
        ST_PROBE,
        ST_DELIVER
    } t_top_state;

    // key and hash sequencer
    typedef enum logic [2:0] {
        K_IDLE,
        K_FLOOR,
        K_HASH,
        K_XOR,
        K_MOD,
        K_DONE
    } t_key_state;

    // table probe engine
    typedef enum logic [1:0] {
        TB_SWEEP,
        TB_IDLE,
        TB_READ,
        TB_CHECK
    } t_tbl_state;

    // status from the table engine to the top level
    typedef struct packed {
        logic busy;
        logic done;
        logic keep;
        logic overflow;
    } t_tbl_stat;

endpackage

// ----- hdl/vfpd_key.sv -----
// vfpd_key: voxel key computation (scale, floor, saturate) and slot hash
// depends on vfpd_pkg
// one point at a time; slot ready in the K_DONE state
module vfpd_key #(
    parameter int TABLE_DEPTH = 4096,
    parameter int KEY_BITS    = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [2:0][vfpd_pkg::COORD_W-1:0]   i_coord,
    input  logic [2:0][vfpd_pkg::INV_W-1:0]     i_inv,
    output logic                                o_done,
    output logic [2:0][KEY_BITS-1:0]            o_key,
    output logic [$clog2(TABLE_DEPTH)-1:0]      o_slot
);
    import vfpd_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam logic signed [32:0] KEY_HI = (33'sd1 <<< (KEY_BITS - 1)) - 33'sd1;
    localparam logic signed [32:0] KEY_LO = -(33'sd1 <<< (KEY_BITS - 1));
    // reciprocal of the table depth, exact floor for every 32-bit hash
    localparam int          REC_SHIFT = 32 + ADDR_W;
    localparam logic [32:0] REC_M     = 33'(((64'd1 << REC_SHIFT) + 64'(TABLE_DEPTH) - 64'd1)
                                            / 64'(TABLE_DEPTH));
    localparam logic [31:0] DEPTH_32  = 32'(TABLE_DEPTH);

    t_key_state r_state, n_state;
    logic signed [2:0][PROD_W-1:0] r_prod;
    logic [2:0][KEY_BITS-1:0] r_key, n_key;
    logic [2:0][31:0] r_hp, n_hp;
    logic [31:0] r_h, n_xor;
    logic [31:0] r_quo, n_quo;
    logic [64:0] rec_prod;
    logic [31:0] rem_full;
    logic [ADDR_W-1:0] n_rem;
    logic [ADDR_W-1:0] r_slot;
    logic r_mod_step;
    logic signed [2:0][PROD_W-1:0] n_prod;
    logic signed [2:0][32:0] q;
    logic [2:0][31:0] k32;

    // scale, floor and saturate per axis, then prime products
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_prod[a] = $signed(i_coord[a]) * $signed({1'b0, i_inv[a]});
            // arithmetic shift by 32 is an exact floor
            q[a] = 33'($signed(r_prod[a][PROD_W-1:32]));
            if ($signed(q[a]) > KEY_HI) begin
                n_key[a] = KEY_HI[KEY_BITS-1:0];
            end else if ($signed(q[a]) < KEY_LO) begin
                n_key[a] = KEY_LO[KEY_BITS-1:0];
            end else begin
                n_key[a] = q[a][KEY_BITS-1:0];
            end
            k32[a] = 32'($signed(r_key[a]));
            n_hp[a] = k32[a] * PRIMES[a];
        end
        n_xor = r_hp[0] ^ r_hp[1] ^ r_hp[2];
    end

    // remainder by the table depth: quotient by reciprocal multiply, then subtract
    always_comb begin
        rec_prod = 65'(r_h) * 65'(REC_M);
        n_quo    = 32'(rec_prod >> REC_SHIFT);
        rem_full = r_h - r_quo * DEPTH_32;
        n_rem    = rem_full[ADDR_W-1:0];
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            K_IDLE:  if (i_start) n_state = K_FLOOR;
            K_FLOOR: n_state = K_HASH;
            K_HASH:  n_state = K_XOR;
            K_XOR:   n_state = IS_POW2 ? K_DONE : K_MOD;
            K_MOD:   if (r_mod_step) n_state = K_DONE;
            K_DONE:  n_state = K_IDLE;
            default: n_state = K_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= K_IDLE;
            r_mod_step <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == K_MOD) begin
                r_mod_step <= !r_mod_step;
            end else begin
                r_mod_step <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == K_IDLE && i_start) begin
            r_prod <= n_prod;
        end
        if (r_state == K_FLOOR) begin
            r_key <= n_key;
        end
        if (r_state == K_HASH) begin
            r_hp <= n_hp;
        end
        if (r_state == K_XOR) begin
            r_h    <= n_xor;
            r_slot <= n_xor[ADDR_W-1:0];
        end
        if (r_state == K_MOD) begin
            if (!r_mod_step) begin
                r_quo <= n_quo;
            end else begin
                r_slot <= n_rem;
            end
        end
    end

    assign o_done = (r_state == K_DONE);
    assign o_key  = r_key;
    assign o_slot = r_slot;

endmodule

// ----- hdl/vfpd_table.sv -----
// vfpd_table: hash table memory with clearing sweep and linear probing
// depends on vfpd_pkg
// each entry holds a valid bit and the three voxel keys
module vfpd_table #(
    parameter int TABLE_DEPTH = 4096,
    parameter int MAX_PROBES  = 8,
    parameter int KEY_BITS    = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_clear,
    input  logic                              i_start,
    input  logic [2:0][KEY_BITS-1:0]          i_key,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    i_slot,
    output vfpd_pkg::t_tbl_stat               o_stat
);
    import vfpd_pkg::*;

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W = 3 * KEY_BITS + 1;
    localparam int PROBE_W = $clog2(MAX_PROBES + 1);
    localparam logic [ADDR_W-1:0]  LAST_ADDR  = ADDR_W'(TABLE_DEPTH - 1);
    localparam logic [PROBE_W-1:0] LAST_PROBE = PROBE_W'(MAX_PROBES - 1);

    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

    t_tbl_state r_state, n_state;
    logic [ADDR_W-1:0] r_slot, n_slot, slot_inc;
    logic [PROBE_W-1:0] r_probe, n_probe;
    logic [3*KEY_BITS-1:0] r_key;
    logic [ENTRY_W-1:0] r_rdata, mem_wdata;
    logic mem_we, mem_re;
    logic rd_valid, rd_match;

    assign slot_inc = (r_slot == LAST_ADDR) ? '0 : r_slot + ADDR_W'(1);
    assign rd_valid = r_rdata[ENTRY_W-1];
    assign rd_match = (r_rdata[ENTRY_W-2:0] == r_key);

    // probe sequencer and memory control
    always_comb begin
        n_state   = r_state;
        n_slot    = r_slot;
        n_probe   = r_probe;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = {1'b1, r_key};
        o_stat.busy     = (r_state != TB_IDLE);
        o_stat.done     = 1'b0;
        o_stat.keep     = 1'b1;
        o_stat.overflow = 1'b0;
        unique case (r_state)
            TB_SWEEP: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                n_slot    = slot_inc;
                if (r_slot == LAST_ADDR) n_state = TB_IDLE;
            end
            TB_IDLE: begin
                if (i_clear) begin
                    n_slot  = '0;
                    n_state = TB_SWEEP;
                end else if (i_start) begin
                    n_slot  = i_slot;
                    n_probe = '0;
                    n_state = TB_READ;
                end
            end
            TB_READ: begin
                mem_re  = 1'b1;
                n_state = TB_CHECK;
            end
            TB_CHECK: begin
                priority if (!rd_valid) begin
                    // free slot: claim it, first point of the voxel
                    mem_we      = 1'b1;
                    o_stat.done = 1'b1;
                    n_state     = TB_IDLE;
                end else if (rd_match) begin
                    o_stat.done = 1'b1;
                    o_stat.keep = 1'b0;
                    n_state     = TB_IDLE;
                end else if (r_probe == LAST_PROBE) begin
                    // probes spent: keep and flag
                    o_stat.done     = 1'b1;
                    o_stat.overflow = 1'b1;
                    n_state         = TB_IDLE;
                end else begin
                    n_slot  = slot_inc;
                    n_probe = r_probe + PROBE_W'(1);
                    n_state = TB_READ;
                end
            end
            default: n_state = TB_IDLE;
        endcase
    end

    // control registers; reset starts the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TB_SWEEP;
            r_slot  <= '0;
            r_probe <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_probe <= n_probe;
        end
    end

    // search key
    always_ff @(posedge i_clk) begin
        if (r_state == TB_IDLE && i_start) begin
            r_key <= i_key;
        end
    end

    // table memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_slot] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= mem[r_slot];
        end
    end

endmodule

// ----- hdl/voxel_first_point_dedup_unit.sv -----
// Flow: an input point passes the key sequencer (floor, hash, xor, plus the modulo reduction
// when TABLE_DEPTH is not a power of two), then one read and compare per probe (up to
// MAX_PROBES) on the table memory's single read port, then the output register.
// One item at a time: a new point is taken only once the last result is in the output register.
// Reset: synchronous active low; afterwards the table is swept with s_axis_tready low;
// configuration writes are taken at any time.
module voxel_first_point_dedup_unit #(
    parameter int TABLE_DEPTH = 4096,
    parameter int MAX_PROBES  = 8,
    parameter int KEY_BITS    = 24,
    parameter int INDEX_BITS  = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_addr,
    input  logic [vfpd_pkg::INV_W-1:0]          i_cfg_wdata,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [vfpd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // coord_x, coord_y, coord_z
    input  logic [0:0]                          s_axis_tuser,  // kind
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [vfpd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // keep, index, overflow, pad
);
    import vfpd_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    t_top_state r_state, n_state;
    logic [2:0][INV_W-1:0] r_inv;
    logic [INDEX_BITS-1:0] r_counter, r_idx;
    logic r_keep, r_ovf;
    logic r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [31:0] idx_ext;

    logic key_start, key_done, tbl_start, tbl_clear, in_ready;
    logic [2:0][KEY_BITS-1:0] key;
    logic [ADDR_W-1:0] slot;
    t_tbl_stat tbl_stat;
    logic in_xfer, out_free;

    assign in_xfer  = s_axis_tvalid && in_ready;
    assign out_free = !r_out_valid || m_axis_tready;

    // key and hash front end
    vfpd_key #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_key (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (key_start),
        .i_coord (s_axis_tdata),
        .i_inv   (r_inv),
        .o_done  (key_done),
        .o_key   (key),
        .o_slot  (slot)
    );

    // hash table and probing
    vfpd_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_PROBES  (MAX_PROBES),
        .KEY_BITS    (KEY_BITS)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (tbl_clear),
        .i_start (tbl_start),
        .i_key   (key),
        .i_slot  (slot),
        .o_stat  (tbl_stat)
    );

    // item control
    always_comb begin
        n_state   = r_state;
        in_ready  = 1'b0;
        key_start = 1'b0;
        tbl_start = 1'b0;
        tbl_clear = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                if (!tbl_stat.busy) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (s_axis_tvalid) begin
                    if (s_axis_tuser[0] == KIND_CLEAR) begin
                        tbl_clear = 1'b1;
                        n_state   = ST_CLEAR;
                    end else begin
                        key_start = 1'b1;
                        n_state   = ST_KEY;
                    end
                end
            end
            ST_KEY: begin
                if (key_done) begin
                    tbl_start = 1'b1;
                    n_state   = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (tbl_stat.done) n_state = ST_DELIVER;
            end
            ST_DELIVER: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_counter   <= '0;
            r_out_valid <= 1'b0;
            r_inv       <= {INV_RESET, INV_RESET, INV_RESET};
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                if (s_axis_tuser[0] == KIND_CLEAR) begin
                    r_counter <= '0;
                end else begin
                    r_counter <= r_counter + INDEX_BITS'(1);
                end
            end
            if (r_state == ST_DELIVER && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_INV_X: r_inv[0] <= i_cfg_wdata;
                    CFG_INV_Y: r_inv[1] <= i_cfg_wdata;
                    CFG_INV_Z: r_inv[2] <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    assign idx_ext = 32'(r_idx);

    // per-item payload
    always_ff @(posedge i_clk) begin
        if (in_xfer && s_axis_tuser[0] == KIND_POINT) begin
            r_idx <= r_counter;
        end
        if (r_state == ST_PROBE && tbl_stat.done) begin
            r_keep <= tbl_stat.keep;
            r_ovf  <= tbl_stat.overflow;
        end
        if (r_state == ST_DELIVER && out_free) begin
            r_out_data <= {2'b00, r_ovf, idx_ext[OUT_INDEX_W-1:0], r_keep};
        end
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- hdl/vfpd_checker.sv -----
// vfpd_checker: port-level checks on the voxel first-point dedup unit
// depends on vfpd_pkg; bound to voxel_first_point_dedup_unit below
module vfpd_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [0:0]                         s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [vfpd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import vfpd_pkg::*;

    // reset starts the table sweep, so no input is taken right after it
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready right after reset");

    // a clear item starts a sweep
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == KIND_CLEAR) |=> !s_axis_tready)
        else $error("input ready in the cycle after a clear transfer");

    // one point in flight at a time
    a_point_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == KIND_POINT) |=> !s_axis_tready)
        else $error("input ready in the cycle after a point transfer");

    // a dropped point never carries the overflow flag
    a_drop_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(!m_axis_tdata[0] && m_axis_tdata[21]))
        else $error("dropped point flagged as overflow");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind voxel_first_point_dedup_unit vfpd_checker u_vfpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
